[src/apl_pkg.sv]
// Shared types, widths, register indexes and reset values of the peak limiter.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package apl_pkg;

  // Sample format: signed fixed point, 1.0 = 2^FRAC_BITS
  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS     = 20;
  localparam int PEAK_BITS     = SAMPLE_BITS + 1;
  localparam int RELEASE_BITS  = 21;
  localparam int THRESH_BITS   = 23;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = THRESH_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESH  = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_STEREO  = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_ADD     = CFG_IDX_BITS'(3);

  // Reset values: release 64/s at 48 kHz, threshold and peak 1.0, floor 0.001
  localparam logic [RELEASE_BITS-1:0] RELEASE_RESET =
    RELEASE_BITS'((64 * (1 << FRAC_BITS)) / 48000);
  localparam logic [THRESH_BITS-1:0]  THRESH_RESET  = THRESH_BITS'(1 << FRAC_BITS);
  localparam logic [THRESH_BITS-1:0]  THRESH_MIN    =
    THRESH_BITS'(((1 << FRAC_BITS) + 999) / 1000);
  localparam logic [PEAK_BITS-1:0]    PEAK_RESET    = PEAK_BITS'(1 << FRAC_BITS);

  // Divider: quotient bits worked out; anything at or above 2^Q_BITS saturates
  localparam int Q_BITS   = SAMPLE_BITS + 1;
  localparam int DIV_BITS = SAMPLE_BITS + FRAC_BITS;
  localparam int HI_BITS  = DIV_BITS - Q_BITS;
  localparam int CNT_BITS = $clog2(Q_BITS);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One classified frame handed from front to back
  typedef struct packed {
    sample_t                left_sample;
    sample_t                right_sample;
    sample_t                left_mix;
    sample_t                right_mix;
    logic [PEAK_BITS-1:0]   peak;
    logic                   stereo;
    logic                   add;
  } job_t;

  // Status of one divider lane
  typedef struct packed {
    logic                   done;
    logic                   ovf;
    logic [Q_BITS-1:0]      quot;
  } div_res_t;

  // Magnitude of a signed sample; the most negative value maps to 2^(SAMPLE_BITS-1)
  function automatic logic [SAMPLE_BITS-1:0] mag_f(sample_t x);
    logic [SAMPLE_BITS-1:0] u;
    u = x;
    mag_f = u[SAMPLE_BITS-1] ? (~u + SAMPLE_BITS'(1)) : u;
  endfunction

endpackage

[src/apl_queue.sv]
// Two-entry queue of classified frames between the front and the back.
// Depends on apl_pkg for job_t and the queue depth.
`timescale 1ns / 1ps

module apl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  apl_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output apl_pkg::job_t pop_data
);
  import apl_pkg::*;

  job_t                  mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0]  cnt_r;
  logic                  push_fire, pop_fire;

  assign push_ready = (cnt_r != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop_fire) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      if (push_fire && !pop_fire) begin
        cnt_r <= cnt_r + QCNT_BITS'(1);
      end else if (pop_fire && !push_fire) begin
        cnt_r <= cnt_r - QCNT_BITS'(1);
      end
    end
  end

endmodule

[src/apl_front.sv]
// Front of the limiter: configuration registers, level detection and peak tracking.
// Depends on apl_pkg; feeds classified frames into apl_queue.
`timescale 1ns / 1ps

module apl_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [apl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [apl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  apl_pkg::sample_t                     in_left_sample,
  input  apl_pkg::sample_t                     in_right_sample,
  input  apl_pkg::sample_t                     in_left_mix,
  input  apl_pkg::sample_t                     in_right_mix,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output apl_pkg::job_t                        push_data
);
  import apl_pkg::*;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_PUSH = 1'b1;

  logic                     state_r, state_nxt;
  logic [RELEASE_BITS-1:0]  release_r;
  logic [THRESH_BITS-1:0]   thresh_r, thresh_val;
  logic                     stereo_r, add_r;
  logic [PEAK_BITS-1:0]     peak_r, peak_nxt;

  sample_t                  lsamp_r, rsamp_r, lmix_r, rmix_r;
  logic                     job_stereo_r, job_add_r;
  logic [PEAK_BITS-1:0]     level_r, level_nxt;

  logic [SAMPLE_BITS-1:0]   lp, rp, m, d, mind;
  logic [PEAK_BITS:0]       decay;
  logic                     in_fire;

  assign in_ready = (state_r == F_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Configuration writes; threshold below 0.001 is raised to 0.001
  assign thresh_val = cfg_data[THRESH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_r <= RELEASE_RESET;
      thresh_r  <= THRESH_RESET;
      stereo_r  <= 1'b0;
      add_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_RELEASE: release_r <= cfg_data[RELEASE_BITS-1:0];
        REG_THRESH:  thresh_r  <= (thresh_val < THRESH_MIN) ? THRESH_MIN : thresh_val;
        REG_STEREO:  stereo_r  <= cfg_data[0];
        REG_ADD:     add_r     <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // Detected level: |L| in mono, max + half of the smaller magnitude in stereo
  always_comb begin
    lp   = mag_f(in_left_sample);
    rp   = mag_f(in_right_sample);
    m    = (lp > rp) ? lp : rp;
    d    = (lp > rp) ? (lp - rp) : (rp - lp);
    mind = m - d;
    if (stereo_r) begin
      level_nxt = PEAK_BITS'(m) + PEAK_BITS'(mind >> 1);
    end else begin
      level_nxt = PEAK_BITS'(lp);
    end
  end

  // Peak update: take a higher level, else decay linearly down to the threshold
  always_comb begin
    decay = {1'b0, peak_r} - (PEAK_BITS + 1)'(release_r);
    if (level_r > peak_r) begin
      peak_nxt = level_r;
    end else if (decay[PEAK_BITS] || (decay[PEAK_BITS-1:0] < PEAK_BITS'(thresh_r))) begin
      peak_nxt = PEAK_BITS'(thresh_r);
    end else begin
      peak_nxt = decay[PEAK_BITS-1:0];
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      lsamp_r      <= in_left_sample;
      rsamp_r      <= in_right_sample;
      lmix_r       <= in_left_mix;
      rmix_r       <= in_right_mix;
      job_stereo_r <= stereo_r;
      job_add_r    <= add_r;
      level_r      <= level_nxt;
    end
  end

  // Hand the frame with its new peak to the queue
  always_comb begin
    push_valid             = (state_r == F_PUSH);
    push_data.left_sample  = lsamp_r;
    push_data.right_sample = rsamp_r;
    push_data.left_mix     = lmix_r;
    push_data.right_mix    = rmix_r;
    push_data.peak         = peak_nxt;
    push_data.stereo       = job_stereo_r;
    push_data.add          = job_add_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_fire) state_nxt = F_PUSH;
      F_PUSH:  if (push_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      peak_r  <= PEAK_RESET;
    end else begin
      state_r <= state_nxt;
      if (push_valid && push_ready) begin
        peak_r <= peak_nxt;
      end
    end
  end

endmodule

[src/apl_div.sv]
// One bit-serial divider lane: |sample| * 2^FRAC_BITS / divisor, one quotient bit a cycle.
// Depends on apl_pkg; quotients of 2^Q_BITS or more are flagged as overflow.
`timescale 1ns / 1ps

module apl_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  apl_pkg::sample_t                 sample,
  input  logic [apl_pkg::PEAK_BITS-1:0]    divisor,
  output apl_pkg::div_res_t                res
);
  import apl_pkg::*;

  logic                   busy_r, done_r, ovf_r;
  logic [CNT_BITS-1:0]    cnt_r;
  logic [PEAK_BITS-1:0]   rem_r, div_r, rem_nxt, div_eff;
  logic [Q_BITS-1:0]      sh_r, sh_nxt;
  logic [DIV_BITS-1:0]    dvd;
  logic [HI_BITS-1:0]     dvd_hi;
  logic [PEAK_BITS:0]     trial;
  logic                   ge;

  // Set up the dividend; the high part must stay below the divisor
  always_comb begin
    dvd     = {mag_f(sample), FRAC_BITS'(0)};
    dvd_hi  = dvd[DIV_BITS-1:Q_BITS];
    div_eff = (divisor == '0) ? PEAK_BITS'(1) : divisor;
  end

  // One restoring step
  always_comb begin
    trial   = {rem_r, sh_r[Q_BITS-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? PEAK_BITS'(trial - {1'b0, div_r}) : trial[PEAK_BITS-1:0];
    sh_nxt  = {sh_r[Q_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= PEAK_BITS'(dvd_hi);
      sh_r  <= dvd[Q_BITS-1:0];
      div_r <= div_eff;
      ovf_r <= (PEAK_BITS'(dvd_hi) >= div_eff);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= sh_nxt;
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(Q_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.ovf  = ovf_r;
  assign res.quot = sh_r;

endmodule

[src/apl_back.sv]
// Back of the limiter: divides both channels by the peak, mixes, saturates, holds the result.
// Depends on apl_pkg and apl_div; pops frames from apl_queue.
`timescale 1ns / 1ps

module apl_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  apl_pkg::job_t        pop_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output apl_pkg::sample_t     out_left_out,
  output apl_pkg::sample_t     out_right_out
);
  import apl_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RUN  = 2'd1;
  localparam logic [1:0] B_DONE = 2'd2;

  localparam sample_t SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [1:0]   state_r, state_nxt;
  job_t         job_r;
  div_res_t     res_left, res_right;
  logic         start, out_load;
  logic         out_valid_r;
  sample_t      out_left_r, out_right_r;

  // Apply the sign, add the mix input if add is set, clamp to the sample range
  function automatic sample_t limit_f(sample_t x, sample_t mix, logic add, div_res_t d);
    logic signed [Q_BITS:0]   qs;
    logic signed [Q_BITS+1:0] y;
    logic [Q_BITS-SAMPLE_BITS+2:0] top;
    qs = signed'({1'b0, d.quot});
    if (x[SAMPLE_BITS-1]) begin
      qs = -qs;
    end
    y   = (Q_BITS + 2)'(qs) + (add ? (Q_BITS + 2)'(mix) : (Q_BITS + 2)'(0));
    top = y[Q_BITS+1:SAMPLE_BITS-1];
    if (d.ovf) begin
      limit_f = x[SAMPLE_BITS-1] ? SAT_MIN : SAT_MAX;
    end else if ((&top) || !(|top)) begin
      limit_f = y[SAMPLE_BITS-1:0];
    end else begin
      limit_f = y[Q_BITS+1] ? SAT_MIN : SAT_MAX;
    end
  endfunction

  assign pop_ready = (state_r == B_IDLE);
  assign start     = pop_valid && pop_ready;
  assign out_load  = (state_r == B_DONE) && (!out_valid_r || out_ready);

  apl_div u_div_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .sample  (pop_data.left_sample),
    .divisor (pop_data.peak),
    .res     (res_left)
  );

  apl_div u_div_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .sample  (pop_data.right_sample),
    .divisor (pop_data.peak),
    .res     (res_right)
  );

  // Hold the frame while its lanes run
  always_ff @(posedge clk) begin
    if (start) begin
      job_r <= pop_data;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (start) state_nxt = B_RUN;
      B_RUN:   if (res_left.done && res_right.done) state_nxt = B_DONE;
      B_DONE:  if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Output register: load when empty or being taken, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= limit_f(job_r.left_sample, job_r.left_mix, job_r.add, res_left);
      out_right_r <= job_r.stereo ?
                     limit_f(job_r.right_sample, job_r.right_mix, job_r.add, res_right) : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

endmodule

[src/audio_peak_limiter.sv]
// Top level of the peak limiter: front, frame queue and divider back end.
// Depends on apl_pkg, apl_front, apl_queue and apl_back.
//
//   channel   ports                                        handshake
//   input     in_left_sample, in_right_sample,             in_valid / in_ready
//             in_left_mix, in_right_mix
//   result    out_left_out, out_right_out                  out_valid / out_ready
//   config    cfg_index, cfg_data                          cfg_wr_en, no wait
//
// From an accepted beat to out_valid a frame passes the front's capture register, the queue,
// the bit-serial divider lanes, the back's wait for both lanes done and the result register.
// The frame rate is set by the divider lanes (one quotient bit a cycle); the front takes no
// new beat until it has pushed the last one, which it can do only while the queue has room.
// Reset (rst_n low, synchronous) sets the peak to 1.0 and the config, state and pointer registers to defaults.
// A stalled result holds; the back finishes its next frame and waits, the queue
// fills and in_ready drops.
`timescale 1ns / 1ps

module audio_peak_limiter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [apl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [apl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  apl_pkg::sample_t                     in_left_sample,
  input  apl_pkg::sample_t                     in_right_sample,
  input  apl_pkg::sample_t                     in_left_mix,
  input  apl_pkg::sample_t                     in_right_mix,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output apl_pkg::sample_t                     out_left_out,
  output apl_pkg::sample_t                     out_right_out
);
  import apl_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  job_t  push_data, pop_data;

  apl_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .in_left_mix     (in_left_mix),
    .in_right_mix    (in_right_mix),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  apl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  apl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out)
  );

endmodule

[src/apl_checker.sv]
// Port-level checks of the peak limiter, bound to the top level.
// Depends on apl_pkg and audio_peak_limiter.
`timescale 1ns / 1ps

module apl_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [apl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [apl_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  apl_pkg::sample_t                     out_left_out,
  input  apl_pkg::sample_t                     out_right_out
);
  import apl_pkg::*;

  logic       stereo_seen_r;
  logic [3:0] pend_r;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Track stereo mode and beats in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_seen_r <= 1'b0;
      pend_r        <= '0;
    end else begin
      if (cfg_wr_en && (cfg_index == REG_STEREO)) begin
        stereo_seen_r <= cfg_data[0];
      end
      pend_r <= pend_r + {3'b0, in_fire} - {3'b0, out_fire};
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_out) && $stable(out_right_out))
    else $error("stalled result changed");

  a_mono_right_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !stereo_seen_r |-> out_right_out == '0)
    else $error("right output not zero in mono");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without an accepted input beat");

endmodule

bind audio_peak_limiter apl_checker u_apl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .cfg_wr_en     (cfg_wr_en),
  .cfg_index     (cfg_index),
  .cfg_data      (cfg_data),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_left_out  (out_left_out),
  .out_right_out (out_right_out)
);
